// ----- rtl/core/hsbe_pkg.sv -----
`timescale 1ns / 1ps

package hsbe_pkg;

   localparam int SYMBOL_BYTES_DEF = 3;
   localparam int SYMBOL_W         = 24;
   localparam int PAT_W            = 32;
   localparam int FILL_W           = 2;
   localparam int COUNT_W          = 3;
   localparam int ACC_W            = 7;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   // register index, taken from paddr[2]
   localparam logic REG_ZERO_SYMBOL = 1'b0;
   localparam logic REG_ONE_SYMBOL  = 1'b1;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] hidden_byte;
      logic       byte_valid;
      logic       message_end;
      logic       incomplete;
   } rsp_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] zero_symbol;
      logic [SYMBOL_W-1:0] one_symbol;
   } cfg_type;

endpackage

// ----- rtl/core/hsbe_csr.sv -----
`timescale 1ns / 1ps

module hsbe_csr
   import hsbe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [SYMBOL_W-1:0] zero_symbol_ff, zero_symbol_in;
   logic [SYMBOL_W-1:0] one_symbol_ff, one_symbol_in;
   logic                wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      zero_symbol_in = zero_symbol_ff;
      one_symbol_in  = one_symbol_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_ZERO_SYMBOL: zero_symbol_in = pwdata[SYMBOL_W-1:0];
            REG_ONE_SYMBOL:  one_symbol_in  = pwdata[SYMBOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_symbol_ff <= '0;
         one_symbol_ff  <= '0;
      end else begin
         zero_symbol_ff <= zero_symbol_in;
         one_symbol_ff  <= one_symbol_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ZERO_SYMBOL: prdata = {(CSR_DATA_W-SYMBOL_W)'(0), zero_symbol_ff};
         REG_ONE_SYMBOL:  prdata = {(CSR_DATA_W-SYMBOL_W)'(0), one_symbol_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.zero_symbol = zero_symbol_ff;
   assign cfg.one_symbol  = one_symbol_ff;

endmodule

// ----- rtl/core/hsbe_decode.sv -----
`timescale 1ns / 1ps

module hsbe_decode
   import hsbe_pkg::*;
#(
   parameter int SYMBOL_BYTES = SYMBOL_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output logic    res_valid,
   output rsp_type res
);

   localparam int WIN_W      = SYMBOL_BYTES * 8;
   localparam int HIST_BYTES = (SYMBOL_BYTES > 1) ? SYMBOL_BYTES - 1 : 1;
   localparam int HIST_W     = HIST_BYTES * 8;
   localparam logic [HIST_W-1:0] HIST_MASK = (SYMBOL_BYTES > 1) ? '1 : '0;
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SYMBOL_BYTES - 1);

   logic [HIST_W-1:0]  hist_ff, hist_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [HIST_W+7:0]  shifted;
   logic [WIN_W-1:0]   win;
   logic [PAT_W-1:0]   zero_ext, one_ext;
   logic               is_one, is_zero, window_full;
   logic               byte_done;
   logic [7:0]         hidden;
   logic               incomplete;

   assign shifted     = {hist_ff, req.message_byte};
   assign win         = shifted[WIN_W-1:0];
   assign zero_ext    = {(PAT_W-SYMBOL_W)'(0), cfg.zero_symbol};
   assign one_ext     = {(PAT_W-SYMBOL_W)'(0), cfg.one_symbol};
   assign is_one      = win == one_ext[WIN_W-1:0];
   assign is_zero     = win == zero_ext[WIN_W-1:0];
   assign window_full = fill_ff >= FILL_FULL;

   always_comb begin
      hist_in    = hist_ff;
      fill_in    = fill_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      byte_done  = 1'b0;
      hidden     = '0;
      incomplete = 1'b0;
      if (accept) begin
         if (window_full) begin
            if (is_one || is_zero) begin
               // one_symbol wins when both patterns match
               if (count_ff == COUNT_W'(7)) begin
                  byte_done = 1'b1;
                  hidden    = {is_one, acc_ff};
                  acc_in    = '0;
                  count_in  = '0;
               end else begin
                  acc_in   = acc_ff | (ACC_W'(is_one) << count_ff);
                  count_in = count_ff + COUNT_W'(1);
               end
               // skip the matched bytes
               hist_in = '0;
               fill_in = '0;
            end else begin
               hist_in = shifted[HIST_W-1:0] & HIST_MASK;
            end
         end else begin
            hist_in = shifted[HIST_W-1:0] & HIST_MASK;
            fill_in = fill_ff + FILL_W'(1);
         end
         if (req.is_last) begin
            incomplete = count_in != '0;
            hist_in    = '0;
            fill_in    = '0;
            acc_in     = '0;
            count_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         fill_ff  <= '0;
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         hist_ff  <= hist_in;
         fill_ff  <= fill_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

   assign res_valid       = accept && (byte_done || req.is_last);
   assign res.hidden_byte = hidden;
   assign res.byte_valid  = byte_done;
   assign res.message_end = req.is_last;
   assign res.incomplete  = incomplete;

endmodule

// ----- rtl/core/hsbe_out_queue.sv -----
`timescale 1ns / 1ps

module hsbe_out_queue
   import hsbe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != 2'd0;
   assign in_ready  = count_ff != 2'd2;
   assign out_data  = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
      if (pop && count_ff == 2'd2) begin
         head_in = tail_ff;
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ----- rtl/core/hidden_symbol_byte_extractor.sv -----
`timescale 1ns / 1ps
// Each result transaction is registered in the output queue and offered on rsp behind any earlier result still waiting.
// Throughput: one input byte per cycle while req_ready is high; window match and bit packing are combinational.
// A two-entry result queue keeps req_ready high while one result waits on rsp.
// Reset (synchronous, active high) clears window, symbol count, queue and both patterns.
// Inputs that complete no byte and are not last produce no result transaction.

module hidden_symbol_byte_extractor
   import hsbe_pkg::*;
#(
   parameter int SYMBOL_BYTES = SYMBOL_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   rsp_type res;
   logic    res_valid;
   logic    accept;

   assign accept = req_valid && req_ready;

   hsbe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hsbe_decode #(
      .SYMBOL_BYTES (SYMBOL_BYTES)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   hsbe_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_rsp_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_valid || rsp_data.message_end))
      else $error("result transaction carries neither a byte nor a message end");

   a_incomplete_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.message_end) |-> !rsp_data.incomplete)
      else $error("incomplete flagged before message end");

   a_empty_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.byte_valid) |-> (rsp_data.hidden_byte == 8'd0))
      else $error("hidden byte nonzero without byte_valid");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.is_last) |=> rsp_valid)
      else $error("last input produced no result transaction");
`endif

endmodule
